>>> hdl/cld_pkg.sv
// package for the content-length deframer
// result record, kind and phase codes, character constants and fixed words
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cld_pkg;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef logic [31:0] msg_len_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    msg_len_t    message_length;
  } result_t;

  // up to two results come out of one input byte
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  // parse phases, one-hot; word mismatch is tracked in a separate flag
  typedef enum logic [9:0] {
    PH_LINE   = 10'b00_0000_0001,
    PH_PREFIX = 10'b00_0000_0010,
    PH_SELECT = 10'b00_0000_0100,
    PH_LWORD  = 10'b00_0000_1000,
    PH_TWORD  = 10'b00_0001_0000,
    PH_LSEP   = 10'b00_0010_0000,
    PH_TSEP   = 10'b00_0100_0000,
    PH_LVALUE = 10'b00_1000_0000,
    PH_TVALUE = 10'b01_0000_0000,
    PH_BODY   = 10'b10_0000_0000
  } phase_t;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_L   = 8'h4C;
  localparam logic [7:0] CH_T   = 8'h54;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [3:0] PREFIX_LEN = 4'd8;
  localparam logic [3:0] LENGTH_LEN = 4'd6;
  localparam logic [3:0] TYPE_LEN   = 4'd4;
  localparam logic [3:0] SEP_LEN    = 4'd2;

  // output queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QLVL_W = 3;

  function automatic logic [7:0] prefix_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = "C";
      3'd1:    c = "o";
      3'd2:    c = "n";
      3'd3:    c = "t";
      3'd4:    c = "e";
      3'd5:    c = "n";
      3'd6:    c = "t";
      default: c = "-";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] length_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = "L";
      3'd1:    c = "e";
      3'd2:    c = "n";
      3'd3:    c = "g";
      3'd4:    c = "t";
      3'd5:    c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] type_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = "T";
      3'd1:    c = "y";
      3'd2:    c = "p";
      3'd3:    c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sep_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = ":";
      3'd1:    c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cld_if.sv
// stream channel interfaces for the content-length deframer
// byte request channel and result channel; valid/ready handshake
`timescale 1ns / 1ps
`default_nettype none

interface cld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;

  modport source (output valid, output byte_req, input ready);
  modport sink   (input valid, input byte_req, output ready);
endinterface

interface cld_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic        last;
  logic [31:0] message_length;

  modport source (output valid, output kind, output data, output last,
                  output message_length, input ready);
  modport sink   (input valid, input kind, input data, input last,
                  input message_length, output ready);
endinterface

`default_nettype wire

>>> hdl/content_length_message_deframer_unit.sv
// content-length deframer top level
// results: the parser is combinational; a request's results are registered in the queue
// throughput: one request per cycle while the queue holds at most two results; a byte
//   that causes an error and an empty message puts two results into the 4-entry queue
// reset: synchronous, active low; clears parse state and queue, no clear pass
`timescale 1ns / 1ps
`default_nettype none

module content_length_message_deframer_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cld_in_if.sink     in_ch,
  cld_out_if.source  out_ch
);

  cld_pkg::push_t                   push;
  logic                             space_ok;
  logic [cld_pkg::QLVL_W-1:0]       level;
  logic                             accept;

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && space_ok;

  cld_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_ch.byte_req),
    .push    (push)
  );

  cld_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .level    (level),
    .out_ch   (out_ch)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= cld_pkg::QLVL_W'(cld_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind != cld_pkg::KIND_BODY) |->
      (out_ch.data == 8'h00 && !out_ch.last && out_ch.message_length == '0))
    else $error("non-body result carries payload");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count == 2'd0 && out_ch.valid && out_ch.ready) |=>
      level == $past(level) - cld_pkg::QLVL_W'(1))
    else $error("queue level lost track of a pop");

  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> push.count == 2'd0)
    else $error("result produced without a request");

endmodule

`default_nettype wire

>>> hdl/cld_parser.sv
// header parser and body counter of the content-length deframer
// updates the parse state for each accepted byte; depends on cld_pkg
`timescale 1ns / 1ps
`default_nettype none

module cld_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    in_byte,
  output cld_pkg::push_t     push
);

  localparam int LB = LENGTH_BITS;

  cld_pkg::phase_t phase_r, phase_nxt;
  logic            bad_r, bad_nxt;
  logic [2:0]      mpos_r, mpos_nxt;
  logic [LB-1:0]   len_r, len_nxt;
  logic            digits_r, digits_nxt;
  logic            type_r, type_nxt;
  logic [LB-1:0]   rem_r, rem_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= cld_pkg::PH_LINE;
      bad_r    <= 1'b0;
      mpos_r   <= 3'd0;
      len_r    <= '0;
      digits_r <= 1'b0;
      type_r   <= 1'b0;
      rem_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      bad_r    <= bad_nxt;
      mpos_r   <= mpos_nxt;
      len_r    <= len_nxt;
      digits_r <= digits_nxt;
      type_r   <= type_nxt;
      rem_r    <= rem_nxt;
    end
  end

  logic [3:0]    word_len;
  logic [7:0]    word_ch;
  logic [3:0]    pos_ext;
  logic [3:0]    pos_inc;
  logic          word_bad;
  logic          word_done;
  logic [3:0]    digit;
  logic [LB-1:0] acc;
  logic [LB+3:0] acc_ext;
  logic [LB+3:0] prod;
  logic          ovf;
  logic [LB-1:0] rem_dec;

  // fixed word at the current phase
  always_comb begin
    case (phase_r)
      cld_pkg::PH_PREFIX: begin
        word_len = cld_pkg::PREFIX_LEN;
        word_ch  = cld_pkg::prefix_char(mpos_r);
      end
      cld_pkg::PH_LWORD: begin
        word_len = cld_pkg::LENGTH_LEN;
        word_ch  = cld_pkg::length_char(mpos_r);
      end
      cld_pkg::PH_TWORD: begin
        word_len = cld_pkg::TYPE_LEN;
        word_ch  = cld_pkg::type_char(mpos_r);
      end
      cld_pkg::PH_LSEP, cld_pkg::PH_TSEP: begin
        word_len = cld_pkg::SEP_LEN;
        word_ch  = cld_pkg::sep_char(mpos_r);
      end
      default: begin
        word_len = cld_pkg::SEP_LEN;
        word_ch  = 8'h00;
      end
    endcase
    pos_ext   = {1'b0, mpos_r};
    pos_inc   = pos_ext + 4'd1;
    word_bad  = bad_r || (pos_ext >= word_len) || (in_byte != word_ch);
    word_done = pos_inc >= word_len;
  end

  // decimal accumulate: acc * 10 + digit, overflow when the top bits are set
  always_comb begin
    digit   = 4'(in_byte - cld_pkg::CH_0);
    acc     = digits_r ? len_r : '0;
    acc_ext = {4'b0000, acc};
    prod    = (acc_ext << 3) + (acc_ext << 1) + {{LB{1'b0}}, digit};
    ovf     = |prod[LB+3:LB];
    rem_dec = rem_r - LB'(1);
  end

  logic clear;
  logic relaunch;
  cld_pkg::result_t err_res;
  cld_pkg::result_t empty_res;
  cld_pkg::result_t body_res;

  always_comb begin
    err_res                = '0;
    err_res.kind           = cld_pkg::KIND_ERROR;
    empty_res              = '0;
    empty_res.kind         = cld_pkg::KIND_EMPTY;
    body_res.kind          = cld_pkg::KIND_BODY;
    body_res.data          = in_byte;
    body_res.last          = (rem_dec == '0);
    body_res.message_length = cld_pkg::msg_len_t'(len_r);

    phase_nxt  = phase_r;
    bad_nxt    = bad_r;
    mpos_nxt   = mpos_r;
    len_nxt    = len_r;
    digits_nxt = digits_r;
    type_nxt   = type_r;
    rem_nxt    = rem_r;
    push       = '0;
    clear      = 1'b0;
    relaunch   = 1'b0;

    if (accept) begin
      case (phase_r)
        cld_pkg::PH_PREFIX, cld_pkg::PH_LWORD, cld_pkg::PH_TWORD,
        cld_pkg::PH_LSEP, cld_pkg::PH_TSEP: begin
          bad_nxt  = word_bad;
          mpos_nxt = pos_inc[2:0];
          if (word_done) begin
            // a type word after a nonempty type value within one header counts as a mismatch
            if (word_bad || (phase_r == cld_pkg::PH_TWORD && type_r)) begin
              push.count = 2'd1;
              push.r0    = err_res;
              clear      = 1'b1;
            end else begin
              bad_nxt  = 1'b0;
              mpos_nxt = 3'd0;
              case (phase_r)
                cld_pkg::PH_PREFIX: phase_nxt = cld_pkg::PH_SELECT;
                cld_pkg::PH_LWORD:  phase_nxt = cld_pkg::PH_LSEP;
                cld_pkg::PH_TWORD:  phase_nxt = cld_pkg::PH_TSEP;
                cld_pkg::PH_LSEP: begin
                  phase_nxt  = cld_pkg::PH_LVALUE;
                  digits_nxt = 1'b0;
                end
                default:            phase_nxt = cld_pkg::PH_TVALUE;
              endcase
            end
          end
        end
        cld_pkg::PH_SELECT: begin
          if (in_byte == cld_pkg::CH_L) begin
            phase_nxt = cld_pkg::PH_LWORD;
            mpos_nxt  = 3'd1;
            bad_nxt   = 1'b0;
          end else if (in_byte == cld_pkg::CH_T) begin
            phase_nxt = cld_pkg::PH_TWORD;
            mpos_nxt  = 3'd1;
            bad_nxt   = 1'b0;
          end else begin
            // error, then the same byte starts a fresh header
            push.count = 2'd1;
            push.r0    = err_res;
            clear      = 1'b1;
            if (in_byte == cld_pkg::CH_LF) begin
              push.count = 2'd2;
              push.r1    = empty_res;
            end else begin
              relaunch = 1'b1;
            end
          end
        end
        cld_pkg::PH_LVALUE: begin
          if (in_byte inside {[cld_pkg::CH_0:cld_pkg::CH_9]}) begin
            if (ovf) begin
              push.count = 2'd1;
              push.r0    = err_res;
              clear      = 1'b1;
            end else begin
              len_nxt    = prod[LB-1:0];
              digits_nxt = 1'b1;
            end
          end else if (!digits_r && (in_byte inside {cld_pkg::CH_SP, cld_pkg::CH_TAB,
                       cld_pkg::CH_LF, cld_pkg::CH_VT, cld_pkg::CH_FF, cld_pkg::CH_CR})) begin
            // skip leading whitespace
          end else if (digits_r && in_byte == cld_pkg::CH_LF) begin
            digits_nxt = 1'b0;
            phase_nxt  = cld_pkg::PH_LINE;
          end else begin
            push.count = 2'd1;
            push.r0    = err_res;
            clear      = 1'b1;
          end
        end
        cld_pkg::PH_TVALUE: begin
          if (in_byte == cld_pkg::CH_LF) begin
            phase_nxt = cld_pkg::PH_LINE;
          end else begin
            type_nxt = 1'b1;
          end
        end
        cld_pkg::PH_BODY: begin
          rem_nxt    = rem_dec;
          push.count = 2'd1;
          push.r0    = body_res;
          if (rem_dec == '0) begin
            clear = 1'b1;
          end
        end
        default: begin
          // line start
          if (in_byte == cld_pkg::CH_LF) begin
            if (len_r == '0) begin
              push.count = 2'd1;
              push.r0    = empty_res;
              clear      = 1'b1;
            end else begin
              rem_nxt   = len_r;
              phase_nxt = cld_pkg::PH_BODY;
            end
          end else begin
            relaunch = 1'b1;
          end
        end
      endcase
    end

    if (clear) begin
      phase_nxt  = cld_pkg::PH_LINE;
      bad_nxt    = 1'b0;
      mpos_nxt   = 3'd0;
      len_nxt    = '0;
      digits_nxt = 1'b0;
      type_nxt   = 1'b0;
      rem_nxt    = '0;
    end
    if (relaunch) begin
      phase_nxt = cld_pkg::PH_PREFIX;
      mpos_nxt  = 3'd1;
      bad_nxt   = (in_byte != cld_pkg::CH_C);
    end
  end

endmodule

`default_nettype wire

>>> hdl/cld_outq.sv
// result queue of the content-length deframer
// takes up to two results a cycle, hands out one; depends on cld_pkg, cld_if
`timescale 1ns / 1ps
`default_nettype none

module cld_outq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cld_pkg::push_t               push,
  output logic                              space_ok,
  output logic [cld_pkg::QLVL_W-1:0]        level,
  cld_out_if.source                         out_ch
);

  cld_pkg::result_t                 mem [cld_pkg::QDEPTH];
  logic [cld_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [cld_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [cld_pkg::QLVL_W-1:0]       level_r, level_nxt;
  logic                             pop;
  logic [cld_pkg::QPTR_W-1:0]       wr_ptr_p1;

  assign pop       = out_ch.valid && out_ch.ready;
  assign wr_ptr_p1 = wr_ptr_r + cld_pkg::QPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + cld_pkg::QPTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + cld_pkg::QPTR_W'(pop);
    level_nxt  = level_r + cld_pkg::QLVL_W'(push.count) - cld_pkg::QLVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  // room for the two results a byte can cause
  assign space_ok = level_r <= cld_pkg::QLVL_W'(cld_pkg::QDEPTH - 2);
  assign level    = level_r;

  assign out_ch.valid          = level_r != '0;
  assign out_ch.kind           = mem[rd_ptr_r].kind;
  assign out_ch.data           = mem[rd_ptr_r].data;
  assign out_ch.last           = mem[rd_ptr_r].last;
  assign out_ch.message_length = mem[rd_ptr_r].message_length;

endmodule

`default_nettype wire

>>> tb/content_length_message_deframer_unit_tb.sv
// testbench for content_length_message_deframer_unit: header parsing, body pass-through,
// empty messages and header errors checked against a byte-level parser model in the bench
// depends on cld_pkg and the channel interfaces cld_in_if / cld_out_if
`timescale 1ns / 1ps

module content_length_message_deframer_unit_tb;

  localparam int unsigned LENGTH_BITS  = 32;
  localparam logic [63:0] LENGTH_MAX   = (64'd1 << LENGTH_BITS) - 64'd1;
  localparam int unsigned RANDOM_BYTES = 1600;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 10;

  localparam logic [63:0] W_PREFIX = "Content-";
  localparam logic [63:0] W_LENGTH = "Length";
  localparam logic [63:0] W_TYPE   = "Type";
  localparam logic [63:0] W_SEP    = ": ";

  typedef enum logic [3:0] {
    ST_LINE, ST_PREFIX, ST_PREFIX_BAD, ST_SELECT, ST_LWORD, ST_LWORD_BAD,
    ST_TWORD, ST_TWORD_BAD, ST_LSEP, ST_LSEP_BAD, ST_TSEP, ST_TSEP_BAD,
    ST_LVALUE, ST_TVALUE, ST_BODY
  } parse_phase_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_THIRD, RX_MOSTLY} rx_mode_t;

  typedef struct {
    logic [7:0] value;
    bit         drain_first;
  } pending_byte_t;

  logic clk;
  logic rst_n;

  cld_in_if  in_ch ();
  cld_out_if out_ch ();

  content_length_message_deframer_unit #(.LENGTH_BITS(LENGTH_BITS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // parser model state
  parse_phase_t parse_phase;
  logic [2:0]   word_pos;
  logic [31:0]  decl_length;
  logic         digit_seen;
  logic         type_given;
  logic [31:0]  body_left;

  cld_pkg::result_t results_due[$];
  pending_byte_t    byte_backlog[$];
  logic [7:0]       frame_bytes[$];

  int unsigned mismatch_count;
  int unsigned accepted_count;
  int unsigned idle_cycles;
  bit          req_taken;
  bit          hold_results;
  int unsigned burst_left;
  int unsigned gap_left;
  rx_mode_t    rx_mode;
  int unsigned rx_left;
  int unsigned rx_count;
  int unsigned hold_points[3] = '{300, 900, 1500};

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------
  task automatic push_result(input cld_pkg::kind_t k, input logic [7:0] d, input logic l,
                             input logic [31:0] n);
    cld_pkg::result_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    r.message_length = n;
    results_due.push_back(r);
  endtask

  task automatic restart_parse();
    parse_phase = ST_LINE;
    word_pos    = '0;
    decl_length = '0;
    digit_seen  = 1'b0;
    type_given  = 1'b0;
    body_left   = '0;
  endtask

  task automatic fail_parse();
    push_result(cld_pkg::KIND_ERROR, 8'h00, 1'b0, 32'd0);
    restart_parse();
  endtask

  task automatic line_start(input logic [7:0] b);
    if (b == cld_pkg::CH_LF) begin
      if (decl_length == 0) begin
        push_result(cld_pkg::KIND_EMPTY, 8'h00, 1'b0, 32'd0);
        restart_parse();
      end else begin
        body_left   = decl_length;
        parse_phase = ST_BODY;
      end
    end else begin
      word_pos    = 3'd1;
      parse_phase = (b == cld_pkg::CH_C) ? ST_PREFIX : ST_PREFIX_BAD;
    end
  endtask

  // a fixed word is always consumed in full, the verdict comes on its last byte
  task automatic match_word(input logic [63:0] word, input int unsigned len,
                            input logic [7:0] b, input parse_phase_t bad, output bit done);
    int unsigned p;
    p = word_pos;
    if (p >= len || b != word[8*(len-1-p) +: 8]) parse_phase = bad;
    p++;
    word_pos = 3'(p);
    done = (p >= len);
  endtask

  function automatic bit is_blank(input logic [7:0] b);
    return b == cld_pkg::CH_SP || b == cld_pkg::CH_TAB || b == cld_pkg::CH_LF ||
           b == cld_pkg::CH_VT || b == cld_pkg::CH_FF || b == cld_pkg::CH_CR;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    bit          done;
    logic [63:0] digit;
    logic [63:0] prior;
    done = 1'b0;
    case (parse_phase)
      ST_PREFIX, ST_PREFIX_BAD: begin
        match_word(W_PREFIX, 8, b, ST_PREFIX_BAD, done);
        if (done) begin
          if (parse_phase == ST_PREFIX_BAD) fail_parse();
          else begin
            parse_phase = ST_SELECT;
            word_pos    = '0;
          end
        end
      end
      ST_SELECT: begin
        if (b == cld_pkg::CH_L) begin
          parse_phase = ST_LWORD;
          word_pos    = 3'd1;
        end else if (b == cld_pkg::CH_T) begin
          parse_phase = ST_TWORD;
          word_pos    = 3'd1;
        end else begin
          // the offending byte opens a new header
          fail_parse();
          line_start(b);
        end
      end
      ST_LWORD, ST_LWORD_BAD: begin
        match_word(W_LENGTH, 6, b, ST_LWORD_BAD, done);
        if (done) begin
          if (parse_phase == ST_LWORD_BAD) fail_parse();
          else begin
            parse_phase = ST_LSEP;
            word_pos    = '0;
          end
        end
      end
      ST_TWORD, ST_TWORD_BAD: begin
        match_word(W_TYPE, 4, b, ST_TWORD_BAD, done);
        if (done) begin
          if (parse_phase == ST_TWORD_BAD || type_given) fail_parse();
          else begin
            parse_phase = ST_TSEP;
            word_pos    = '0;
          end
        end
      end
      ST_LSEP, ST_LSEP_BAD: begin
        match_word(W_SEP, 2, b, ST_LSEP_BAD, done);
        if (done) begin
          if (parse_phase == ST_LSEP_BAD) fail_parse();
          else begin
            parse_phase = ST_LVALUE;
            word_pos    = '0;
            digit_seen  = 1'b0;
          end
        end
      end
      ST_TSEP, ST_TSEP_BAD: begin
        match_word(W_SEP, 2, b, ST_TSEP_BAD, done);
        if (done) begin
          if (parse_phase == ST_TSEP_BAD) fail_parse();
          else begin
            parse_phase = ST_TVALUE;
            word_pos    = '0;
          end
        end
      end
      ST_LVALUE: begin
        if (b >= cld_pkg::CH_0 && b <= cld_pkg::CH_9) begin
          digit = 64'(b - cld_pkg::CH_0);
          prior = digit_seen ? 64'(decl_length) : 64'd0;
          if (prior > (LENGTH_MAX - digit) / 10) fail_parse();
          else begin
            decl_length = 32'(prior * 10 + digit);
            digit_seen  = 1'b1;
          end
        end else if (!digit_seen && is_blank(b)) begin
          // leading whitespace is skipped
        end else if (digit_seen && b == cld_pkg::CH_LF) begin
          digit_seen  = 1'b0;
          parse_phase = ST_LINE;
        end else begin
          fail_parse();
        end
      end
      ST_TVALUE: begin
        if (b == cld_pkg::CH_LF) parse_phase = ST_LINE;
        else type_given = 1'b1;
      end
      ST_BODY: begin
        if (body_left != 0) body_left--;
        push_result(cld_pkg::KIND_BODY, b, body_left == 0, decl_length);
        if (body_left == 0) restart_parse();
      end
      default: line_start(b);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------
  task automatic add_text(input string s);
    foreach (s[i]) frame_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] blank_char(input int unsigned k);
    case (k)
      0:       return cld_pkg::CH_SP;
      1:       return cld_pkg::CH_TAB;
      2:       return cld_pkg::CH_LF;
      3:       return cld_pkg::CH_VT;
      4:       return cld_pkg::CH_FF;
      default: return cld_pkg::CH_CR;
    endcase
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r <= 7) return $urandom_range(1, 8);
    if (r == 8) return $urandom_range(9, 30);
    return $urandom_range(31, 64);
  endfunction

  task automatic add_length_line(input longint unsigned n);
    add_text("Content-Length: ");
    repeat ($urandom_range(0, 2)) frame_bytes.push_back(blank_char($urandom_range(0, 5)));
    if ($urandom_range(0, 4) == 0) add_text("0");
    add_text($sformatf("%0d\n", n));
  endtask

  task automatic add_type_line(input int unsigned n);
    logic [7:0] c;
    add_text("Content-Type: ");
    repeat (n) begin
      c = 8'($urandom_range(0, 254));
      if (c >= cld_pkg::CH_LF) c++;
      frame_bytes.push_back(c);
    end
    add_text("\n");
  endtask

  task automatic add_body(input int unsigned n);
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic flush_frame(input bit drain, input int unsigned hdr_len, input bit corrupt);
    pending_byte_t p;
    if (corrupt && hdr_len != 0)
      frame_bytes[$urandom_range(0, hdr_len - 1)] = 8'($urandom_range(0, 255));
    foreach (frame_bytes[i]) begin
      p.value       = frame_bytes[i];
      p.drain_first = drain && (i == 0);
      byte_backlog.push_back(p);
    end
    frame_bytes.delete();
  endtask

  task automatic put_random_message(input bit drain);
    int unsigned lines;
    int unsigned body_len;
    int unsigned hdr_len;
    int unsigned pick;
    bit          typed;
    body_len = 0;
    typed    = 1'b0;
    if ($urandom_range(0, 99) < 8) begin
      add_body($urandom_range(1, 8));
      flush_frame(drain, 0, 1'b0);
    end else begin
      lines = $urandom_range(0, 3);
      repeat (lines) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          body_len = pick_length();
          add_length_line(body_len);
        end else if (pick < 85) begin
          // a second type line is mostly empty; any type line after a nonempty one makes a header error
          if (typed && $urandom_range(0, 3) != 0) add_type_line(0);
          else begin
            add_type_line($urandom_range(1, 5));
            typed = 1'b1;
          end
        end else if (pick < 93) begin
          // ten-digit length, about half of them overflow, then a small one replaces it
          add_length_line(longint'($urandom_range(1000000000, 2000000000)) * 3 +
                          $urandom_range(0, 2));
          body_len = pick_length();
          add_length_line(body_len);
        end else begin
          add_type_line(0);
        end
      end
      add_text("\n");
      hdr_len = frame_bytes.size();
      add_body(body_len);
      flush_frame(drain, hdr_len, $urandom_range(0, 9) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // request driver, result receiver, monitor
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    nxt_valid = in_ch.valid;
    nxt_byte  = in_ch.byte_req;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_ch.valid || req_taken) begin
      nxt_valid = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (byte_backlog.size() != 0 &&
                   !(byte_backlog[0].drain_first && results_due.size() != 0)) begin
        nxt_valid = 1'b1;
        nxt_byte  = byte_backlog[0].value;
        byte_backlog.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
    in_ch.valid    <= nxt_valid;
    in_ch.byte_req <= nxt_byte;
  end

  always @(negedge clk) begin
    logic rdy;
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 100);
    end else begin
      rx_left--;
    end
    rx_count++;
    case (rx_mode)
      RX_ALWAYS: rdy = 1'b1;
      RX_COIN:   rdy = 1'($urandom_range(0, 1));
      RX_THIRD:  rdy = (rx_count % 3 == 0);
      default:   rdy = ($urandom_range(0, 7) != 0);
    endcase
    out_ch.ready <= rst_n && !hold_results && rdy;
  end

  task automatic check_result();
    cld_pkg::result_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with nothing pending, kind", 32'(out_ch.kind), 32'd0);
    end else begin
      want = results_due.pop_front();
      if (out_ch.kind !== want.kind)
        report_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
      if (out_ch.data !== want.data)
        report_mismatch("data", 32'(out_ch.data), 32'(want.data));
      if (out_ch.last !== want.last)
        report_mismatch("last", 32'(out_ch.last), 32'(want.last));
      if (out_ch.message_length !== want.message_length)
        report_mismatch("message_length", out_ch.message_length, want.message_length);
    end
  endtask

  always @(posedge clk) begin
    bit got_result;
    req_taken  = rst_n && in_ch.valid && in_ch.ready;
    got_result = rst_n && out_ch.valid && out_ch.ready;
    if (rst_n) begin
      // the request is modeled first so that a same-edge result still finds it
      if (req_taken) begin
        deframe_byte(in_ch.byte_req);
        accepted_count++;
      end
      if (got_result) check_result();
      if (req_taken || got_result) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // long receiver hold-offs so the result queue fills and requests back up
  initial begin
    hold_results = 1'b0;
    foreach (hold_points[i]) begin
      while (accepted_count < hold_points[i]) @(posedge clk);
      hold_results = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_results = 1'b0;
    end
  end

  initial begin
    while (rst_n !== 1'b1) @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned msg_no;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.byte_req = 8'h00;
    out_ch.ready   = 1'b0;
    mismatch_count = 0;
    accepted_count = 0;
    idle_cycles    = 0;
    req_taken      = 1'b0;
    burst_left     = 0;
    gap_left       = 0;
    rx_mode        = RX_ALWAYS;
    rx_left        = 0;
    rx_count       = 0;
    restart_parse();

    // empty line with no length, zero length, one-byte body
    add_text("\nContent-Length: 0\n\nContent-Length: 1\n\n");
    frame_bytes.push_back(8'h00);
    add_text("Content-Type: json\nContent-Length: 2\n\n");
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h80);
    // every kind of leading whitespace, then an empty type
    add_text("Content-Length: ");
    for (int k = 0; k < 6; k++) frame_bytes.push_back(blank_char(k));
    add_text("3\nContent-Type: \n\nabc");
    // neither L nor T: error, then LF makes an empty message on the same byte
    add_text("Content-\n");
    // neither L nor T: the C starts a fresh header
    add_text("Content-Content-Length: 1\n\nq");
    // repeated nonempty type
    add_text("Content-Type: a\nContent-Type");
    // overflow by one, and overflow on the tenth digit
    add_text("Content-Length: 4294967296Content-Length: 9999999999");
    flush_frame(1'b0, 0, 1'b0);
    // largest length, replaced by a later one; wait for the queue to empty first
    add_text("Content-Length: 4294967295\nContent-Length: 2\n\nZZ");
    flush_frame(1'b1, 0, 1'b0);
    // broken words and separators, bad digits
    add_text("Xontent-Content-LengtxContent-Length;xContent-TyxeContent-Type:x");
    add_text("Content-Length: 12 Content-Length: x");
    // byte extremes at line start
    frame_bytes.push_back(8'hFF);
    repeat (7) frame_bytes.push_back(8'h00);
    flush_frame(1'b0, 0, 1'b0);

    msg_no = 0;
    while (byte_backlog.size() < RANDOM_BYTES) begin
      msg_no++;
      put_random_message(msg_no % 37 == 0);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_backlog.size() != 0 || in_ch.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch("results never delivered", results_due.size(), 32'd0);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
